[hw/rtl/double_polynomial_hash_defines.svh]
// Assertion macros used by the checker of the double polynomial hash.
`ifndef DOUBLE_POLYNOMIAL_HASH_DEFINES_SVH
`define DOUBLE_POLYNOMIAL_HASH_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DPH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dph_pkg.sv]
// Shared types, constants and table builder for the double polynomial hash.
`timescale 1ns / 1ps

package dph_pkg;

    localparam int unsigned MOD_A  = 1000000007;
    localparam int unsigned MOD_B  = 992837507;
    localparam int unsigned BASE_A = 31;
    localparam int unsigned BASE_B = 29;

    localparam int HASH_W    = 30;
    localparam int SYM_W     = 8;
    localparam int LEN_W     = 12;
    localparam int LEN_CMP_W = 20;
    localparam int TAB_MAX   = 4095;

    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 64;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_MERGE  = 1'b1;

    typedef struct packed {
        logic accept;
        logic merge;
        logic last;
        logic err;
    } lane_ctl_t;

    // multiples of p just below k * 2^27, indexed by the top byte of a 35-bit value
    typedef logic [34:0] red_tab_t [256];

    function automatic red_tab_t red_table(input logic [29:0] p);
        red_tab_t    t;
        logic [34:0] m;
        logic [34:0] bound;
        m = '0;
        for (int k = 0; k < 256; k++) begin
            bound = 35'(k) << 27;
            if (m + 35'(p) <= bound) begin
                m = m + 35'(p);
            end
            t[k] = m;
        end
        return t;
    endfunction

endpackage

[hw/rtl/dph_lane.sv]
// One modulus lane: power table, accumulator and merge multiply-reduce pipeline.
`timescale 1ns / 1ps

module dph_lane #(
    parameter int unsigned MOD   = 1000000007,
    parameter int unsigned BASE  = 31,
    parameter int          DEPTH = 4096,
    parameter int          AW    = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dph_pkg::lane_ctl_t          ctl,
    input  logic [8:0]                  sym_val,
    input  logic [dph_pkg::HASH_W-1:0]  left,
    input  logic [dph_pkg::HASH_W-1:0]  right,
    input  logic [AW-1:0]               raddr,
    output logic                        built,
    output logic [dph_pkg::HASH_W-1:0]  hash
);

    localparam logic [29:0]        P        = 30'(MOD);
    localparam logic [31:0]        P32      = 32'(MOD);
    localparam logic [31:0]        P2       = 32'(2 * 64'(MOD));
    localparam logic [4:0]         BASE_V   = 5'(BASE);
    localparam logic [32:0]        BM       = 33'(64'h4000_0000_0000_0000 / 64'(MOD));
    localparam logic [AW-1:0]      LAST_IDX = AW'(DEPTH - 1);
    localparam dph_pkg::red_tab_t  RED      = dph_pkg::red_table(P);

    typedef enum logic {
        ST_BUILD,
        ST_RUN
    } state_t;

    state_t       state_reg;
    logic [AW-1:0] widx_reg;
    logic [29:0]  cur_reg;
    logic [29:0]  cur_next;

    logic [29:0]  mem [DEPTH];
    logic [29:0]  pw_reg;

    logic [29:0]  acc_reg;
    logic [29:0]  acc_next;
    logic [29:0]  acc_new;

    logic [29:0]  l1_reg, l1_next;
    logic [29:0]  r1_reg, r1_next;
    logic [60:0]  y2_reg, y2_next;
    logic [31:0]  q3_reg, q3_next;
    logic [31:0]  ylo3_reg;
    logic [31:0]  r4_reg, r4_next;

    logic [59:0]  prod;
    logic [64:0]  bq;
    logic [31:0]  qp;

    // v < 2^35 and p > 2^27: one table step plus one conditional subtract
    function automatic logic [29:0] red_small(input logic [34:0] v);
        logic [34:0] d;
        logic [30:0] r;
        d = v - RED[v[34:27]];
        r = d[30:0];
        if (r >= {1'b0, P}) begin
            red_small = 30'(r - {1'b0, P});
        end else begin
            red_small = r[29:0];
        end
    endfunction

    assign cur_next = red_small({5'b0, cur_reg} * {30'b0, BASE_V});
    assign acc_new  = red_small({5'b0, acc_reg} * {30'b0, BASE_V} + {26'b0, sym_val});
    assign built    = (state_reg == ST_RUN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_BUILD;
            widx_reg  <= '0;
            cur_reg   <= 30'd1;
        end else begin
            case (state_reg)
                ST_BUILD: begin
                    cur_reg  <= cur_next;
                    widx_reg <= widx_reg + 1'b1;
                    if (widx_reg == LAST_IDX) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    state_reg <= ST_RUN;
                end
                default: begin
                    state_reg <= ST_BUILD;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_BUILD) begin
            mem[widx_reg] <= cur_reg;
        end
        pw_reg <= mem[raddr];
    end

    always_comb begin
        acc_next = acc_reg;
        if (ctl.accept && !ctl.merge) begin
            acc_next = ctl.last ? '0 : acc_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    // absorb and error beats ride the same path with left = 0
    always_comb begin
        l1_next  = (ctl.merge && !ctl.err) ? left : '0;
        r1_next  = ctl.merge ? (ctl.err ? '0 : right) : acc_new;
        prod     = l1_reg * pw_reg;
        y2_next  = {1'b0, prod} + {31'b0, r1_reg};
        bq       = y2_reg[60:29] * BM;
        q3_next  = bq[64:33];
        qp       = q3_reg * {2'b0, P};
        r4_next  = ylo3_reg - qp;
    end

    always_ff @(posedge aclk) begin
        l1_reg   <= l1_next;
        r1_reg   <= r1_next;
        y2_reg   <= y2_next;
        q3_reg   <= q3_next;
        ylo3_reg <= y2_reg[31:0];
        r4_reg   <= r4_next;
    end

    // Barrett estimate leaves r4 below 3p
    always_comb begin
        if (r4_reg >= P2) begin
            hash = 30'(r4_reg - P2);
        end else if (r4_reg >= P32) begin
            hash = 30'(r4_reg - P32);
        end else begin
            hash = r4_reg[29:0];
        end
    end

endmodule

[hw/rtl/double_polynomial_hash.sv]
// Top level of the double polynomial hash: stream ports, beat tracking, output queue.
// Usage:
//   Input beats on s_*: tuser[0] is cmd. cmd absorb folds tdata symbol into both
//   running hashes; tlast closes the string and emits the hash pair, then the
//   accumulators clear. cmd merge emits (left*base^right_len + right) mod p for
//   both moduli; a right_len above MAX_LEN emits zeros with len_error set.
//   Absorb beats without tlast give no result.
//   Result beats on m_*: tdata holds hash_a and hash_b, tuser[0] is len_error.
//   Result path: lane operand, sum, quotient and remainder registers, then queue.
//   Throughput: one input beat per cycle while s_tready is high, bounded by the
//   accumulator loop: one multiply-by-base and reduction per cycle in each lane.
//   Reset: both power tables are rebuilt, one entry per cycle, filling
//   min(MAX_LEN, 4095) + 1 entries (4096 at the default); s_tready stays low
//   until that pass completes.
//   Stall: results collect in an eight-entry queue; s_tready drops only when the
//   queue plus the beats in flight would fill it, and no result is ever lost.
`timescale 1ns / 1ps

module double_polynomial_hash #(
    parameter int MAX_LEN     = 4095,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // symbol[7:0], left_a[37:8], left_b[67:38], right_a[97:68], right_b[127:98],
    // right_len[139:128], zero fill
    input  logic [dph_pkg::S_TDATA_W-1:0]  s_tdata,
    // cmd[0]
    input  logic [0:0]                     s_tuser,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // hash_a[29:0], hash_b[59:30], zero fill
    output logic [dph_pkg::M_TDATA_W-1:0]  m_tdata,
    // len_error[0]
    output logic [0:0]                     m_tuser
);

    localparam int SB        = (SYMBOL_BITS < dph_pkg::SYM_W) ? SYMBOL_BITS : dph_pkg::SYM_W;
    localparam logic [dph_pkg::SYM_W-1:0] SYM_MASK = dph_pkg::SYM_W'((1 << SB) - 1);
    localparam int TAB_DEPTH = ((MAX_LEN < dph_pkg::TAB_MAX) ? MAX_LEN : dph_pkg::TAB_MAX) + 1;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);
    localparam logic [dph_pkg::LEN_CMP_W-1:0] MAX_LEN_V = dph_pkg::LEN_CMP_W'(MAX_LEN);
    localparam logic [dph_pkg::FIFO_AW:0]     FIFO_FULL = (dph_pkg::FIFO_AW + 1)'(dph_pkg::FIFO_DEPTH);

    logic [dph_pkg::SYM_W-1:0]  symbol;
    logic [dph_pkg::HASH_W-1:0] left_a, left_b, right_a, right_b;
    logic [dph_pkg::LEN_W-1:0]  right_len;
    logic [8:0]                 sym_val;
    logic [TAB_AW-1:0]          tab_addr;

    logic               accept;
    logic               is_merge;
    logic               len_err;
    logic               has_result;
    dph_pkg::lane_ctl_t ctl;

    logic built_a, built_b;
    logic [dph_pkg::HASH_W-1:0] hash_a, hash_b;

    logic [3:0] v_reg, v_next;
    logic [3:0] err_reg, err_next;
    logic [2:0] inflight;

    logic [60:0]                fifo_mem [dph_pkg::FIFO_DEPTH];
    logic [dph_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dph_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dph_pkg::FIFO_AW:0]   cnt_reg, cnt_next;
    logic                        fifo_wr, fifo_rd;
    logic [60:0]                 head;

    assign symbol    = s_tdata[7:0];
    assign left_a    = s_tdata[37:8];
    assign left_b    = s_tdata[67:38];
    assign right_a   = s_tdata[97:68];
    assign right_b   = s_tdata[127:98];
    assign right_len = s_tdata[139:128];
    assign sym_val   = {1'b0, symbol & SYM_MASK} + 9'd1;

    assign inflight = 3'(v_reg[0]) + 3'(v_reg[1]) + 3'(v_reg[2]) + 3'(v_reg[3]);
    assign s_tready = built_a && built_b && ((cnt_reg + 4'(inflight)) < FIFO_FULL);

    assign accept     = s_tvalid && s_tready;
    assign is_merge   = (s_tuser[0] == dph_pkg::CMD_MERGE);
    assign len_err    = is_merge && ({8'b0, right_len} > MAX_LEN_V);
    assign has_result = is_merge || s_tlast;

    // table reads stay inside the built range
    assign tab_addr = (is_merge && !len_err) ? right_len[TAB_AW-1:0] : '0;

    assign ctl = '{accept: accept, merge: is_merge, last: s_tlast, err: len_err};

    dph_lane #(
        .MOD   (dph_pkg::MOD_A),
        .BASE  (dph_pkg::BASE_A),
        .DEPTH (TAB_DEPTH),
        .AW    (TAB_AW)
    ) u_lane_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .sym_val (sym_val),
        .left    (left_a),
        .right   (right_a),
        .raddr   (tab_addr),
        .built   (built_a),
        .hash    (hash_a)
    );

    dph_lane #(
        .MOD   (dph_pkg::MOD_B),
        .BASE  (dph_pkg::BASE_B),
        .DEPTH (TAB_DEPTH),
        .AW    (TAB_AW)
    ) u_lane_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .sym_val (sym_val),
        .left    (left_b),
        .right   (right_b),
        .raddr   (tab_addr),
        .built   (built_b),
        .hash    (hash_b)
    );

    assign fifo_wr = v_reg[3];
    assign fifo_rd = m_tvalid && m_tready;

    always_comb begin
        v_next      = {v_reg[2:0], accept && has_result};
        err_next    = {err_reg[2:0], len_err};
        wr_ptr_next = fifo_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = fifo_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + {3'b0, fifo_wr} - {3'b0, fifo_rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg      <= '0;
            err_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            v_reg      <= v_next;
            err_reg    <= err_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fifo_wr) begin
            fifo_mem[wr_ptr_reg] <= {err_reg[3], hash_b, hash_a};
        end
    end

    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {4'b0, head[59:0]};
    assign m_tuser  = head[60];

endmodule

[hw/rtl/dph_checker.sv]
// Port-level checker for the double polynomial hash, bound to the top level.
`timescale 1ns / 1ps
`include "double_polynomial_hash_defines.svh"

module dph_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dph_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser
);

    `DPH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
    `DPH_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser[0], m_tdata[59:0] == 60'd0, "length error beat carries nonzero hashes")
    `DPH_ASSERT_NOW(a_hash_range, m_tvalid, (m_tdata[29:0] < 30'(dph_pkg::MOD_A)) && (m_tdata[59:30] < 30'(dph_pkg::MOD_B)), "hash not reduced below its modulus")

endmodule

bind double_polynomial_hash dph_checker u_dph_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
